/* rtl/srll_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srll_pkg
// Shared types, constants and helpers for the S-record line loader.
// ----------------------------------------------------------------------------
package srll_pkg;

  localparam int MEM_BYTES   = 262144;
  localparam int MEM_AW      = 18;
  localparam int LINE_BYTES  = 128;
  localparam int LINE_AW     = 7;
  localparam int ERASE_BLOCK = 4096;
  localparam int KERNEL_AREA = 32768;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CHAR  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_1    = 8'h31;
  localparam logic [7:0] CHAR_2    = 8'h32;
  localparam logic [7:0] CHAR_8    = 8'h38;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [9:0] POS_CAP   = 10'd1023;
  localparam logic [23:0] ADDR_CAP = 24'hFFFFFF;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_START,
    OP_CHAR,
    OP_EOL,
    OP_READ
  } op_code_t;

  typedef struct packed {
    op_code_t    code;
    logic [7:0]  ch;
    logic [17:0] addr;
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_S     = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_BAD_ADDR = 3'd3,
    ST_TYPE     = 3'd4,
    ST_LENGTH   = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_CHECK,
    BK_WR_RD,
    BK_WR_WR,
    BK_READ,
    BK_EMIT
  } back_state_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) begin
      return {1'b0, c[3:0]};
    end
    return {1'b0, c[3:0]} + 5'd9;
  endfunction

  function automatic logic [1:0] addr_len(input logic [7:0] k);
    if (k == CHAR_2) begin
      return 2'd3;
    end
    if (k == CHAR_1) begin
      return 2'd2;
    end
    return 2'd0;
  endfunction

endpackage

/* rtl/srll_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srll_front
// Input stage: registers each request and classifies it into an operation.
// ----------------------------------------------------------------------------
module srll_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      command,
  input  logic [7:0]      char_code,
  input  logic [17:0]     read_address,
  output logic            op_valid,
  input  logic            op_stall,
  output srll_pkg::op_t   op
);

  logic          held;
  srll_pkg::op_t op_r;
  srll_pkg::op_t op_class;

  assign in_stall = held && op_stall;
  assign op_valid = held;
  assign op       = op_r;

  always_comb begin
    op_class.ch   = char_code;
    op_class.addr = read_address;
    case (command)
      srll_pkg::CMD_CLEAR: op_class.code = srll_pkg::OP_CLEAR;
      srll_pkg::CMD_START: op_class.code = srll_pkg::OP_START;
      srll_pkg::CMD_CHAR: begin
        op_class.code = (char_code == srll_pkg::CHAR_LF) ? srll_pkg::OP_EOL
                                                         : srll_pkg::OP_CHAR;
      end
      default: op_class.code = srll_pkg::OP_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r <= op_class;
    end
  end

endmodule

/* rtl/srll_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srll_queue
// Short operation queue between the front and back parts.
// ----------------------------------------------------------------------------
module srll_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  srll_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop,
  output srll_pkg::op_t pop_op
);

  srll_pkg::op_t                  slots [srll_pkg::QUEUE_DEPTH];
  logic [srll_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [srll_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [srll_pkg::QUEUE_AW:0]    fill;
  logic                           do_push;
  logic                           do_pop;

  assign push_stall = (fill == (srll_pkg::QUEUE_AW+1)'(srll_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!do_push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

/* rtl/srll_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srll_back
// Execution part: line decoding, line check and write-back, memory clear,
// memory reads and the result register.
// ----------------------------------------------------------------------------
module srll_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_pop,
  input  srll_pkg::op_t op,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          kind,
  output logic [2:0]    status,
  output logic [23:0]   bad_address,
  output logic [18:0]   max_address,
  output logic [7:0]    read_data
);

  logic [7:0] pmem [srll_pkg::MEM_BYTES];
  logic [7:0] line_mem [srll_pkg::LINE_BYTES];

  srll_pkg::back_state_t state, state_next;
  logic [17:0] clr_cnt, clr_cnt_next;
  logic [9:0]  pos, pos_next;
  logic [7:0]  rkind, rkind_next;
  logic [7:0]  bc, bc_next;
  logic [4:0]  pend, pend_next;
  logic [7:0]  rsum, rsum_next;
  logic [23:0] raddr, raddr_next;
  srll_pkg::status_t fault, fault_next;
  logic [18:0] hw, hw_next;
  logic        latched, latched_next;
  logic [7:0]  k, k_next;
  logic [1:0]  alen, alen_next;
  logic [17:0] ra_r, ra_r_next;
  logic        res_kind, res_kind_next;
  srll_pkg::status_t res_status, res_status_next;
  logic [23:0] res_bad, res_bad_next;

  logic        pm_we;
  logic [17:0] pm_wa;
  logic [7:0]  pm_wd;
  logic [7:0]  pm_q;
  logic        lb_we;
  logic [6:0]  lb_wa;
  logic [7:0]  lb_wd;
  logic [6:0]  lb_ra;
  logic [7:0]  lb_q;
  logic        emit_load;

  logic [4:0]  h;
  logic [9:0]  lim;
  logic [9:0]  dpos;
  logic [2:0]  digits;
  logic [2:0]  dd;
  logic [24:0] addsum;
  logic [8:0]  v;
  logic [9:0]  idx;
  logic [24:0] wa_full;
  logic [7:0]  ndata;

  assign h       = srll_pkg::hex_value(op.ch);
  assign lim     = 10'd4 + {1'b0, bc, 1'b0};
  assign dpos    = pos - 10'd4;
  assign digits  = {srll_pkg::addr_len(rkind), 1'b0};
  assign dd      = digits - 3'd1 - dpos[2:0];
  assign addsum  = {1'b0, raddr} + ({20'd0, h} << {dd, 2'b00});
  assign v       = {pend, 4'b0000} + {4'd0, h};
  assign idx     = (pos - 10'd5) >> 1;
  assign wa_full = {1'b0, raddr} + {17'd0, k};
  assign ndata   = bc - 8'd1 - {6'd0, alen};
  assign lb_ra   = 7'(alen + k);

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_wa] <= pm_wd;
    end
    pm_q <= pmem[ra_r];
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      line_mem[lb_wa] <= lb_wd;
    end
    lb_q <= line_mem[lb_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= srll_pkg::BK_IDLE;
      pos     <= '0;
      rkind   <= '0;
      bc      <= '0;
      pend    <= '0;
      rsum    <= '0;
      raddr   <= '0;
      fault   <= srll_pkg::ST_OK;
      hw      <= '0;
      latched <= 1'b0;
    end else begin
      state   <= state_next;
      pos     <= pos_next;
      rkind   <= rkind_next;
      bc      <= bc_next;
      pend    <= pend_next;
      rsum    <= rsum_next;
      raddr   <= raddr_next;
      fault   <= fault_next;
      hw      <= hw_next;
      latched <= latched_next;
    end
  end

  always_ff @(posedge clk) begin
    clr_cnt    <= clr_cnt_next;
    k          <= k_next;
    alen       <= alen_next;
    ra_r       <= ra_r_next;
    res_kind   <= res_kind_next;
    res_status <= res_status_next;
    res_bad    <= res_bad_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      kind        <= res_kind;
      status      <= res_status;
      bad_address <= res_bad;
      max_address <= hw;
      read_data   <= res_kind ? pm_q : 8'd0;
    end
  end

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    pos_next        = pos;
    rkind_next      = rkind;
    bc_next         = bc;
    pend_next       = pend;
    rsum_next       = rsum;
    raddr_next      = raddr;
    fault_next      = fault;
    hw_next         = hw;
    latched_next    = latched;
    k_next          = k;
    alen_next       = alen;
    ra_r_next       = ra_r;
    res_kind_next   = res_kind;
    res_status_next = res_status;
    res_bad_next    = res_bad;
    op_pop          = 1'b0;
    pm_we           = 1'b0;
    pm_wa           = clr_cnt;
    pm_wd           = 8'hFF;
    lb_we           = 1'b0;
    lb_wa           = idx[6:0];
    lb_wd           = v[7:0];
    emit_load       = 1'b0;

    case (state)
      srll_pkg::BK_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          case (op.code)
            srll_pkg::OP_CLEAR: begin
              clr_cnt_next = '0;
              state_next   = srll_pkg::BK_CLEAR;
            end
            srll_pkg::OP_START: begin
              pos_next     = '0;
              rkind_next   = '0;
              bc_next      = '0;
              pend_next    = '0;
              rsum_next    = '0;
              raddr_next   = '0;
              fault_next   = srll_pkg::ST_OK;
              hw_next      = '0;
              latched_next = 1'b0;
            end
            srll_pkg::OP_CHAR: begin
              if (!latched) begin
                if (pos == 10'd0) begin
                  if (op.ch != srll_pkg::CHAR_S) begin
                    fault_next = srll_pkg::ST_NO_S;
                  end
                end else if (pos == 10'd1) begin
                  rkind_next = op.ch;
                end else begin
                  if (pos >= 10'd4 && pos < lim && dpos < {7'd0, digits}) begin
                    raddr_next = (addsum > {1'b0, srll_pkg::ADDR_CAP}) ?
                                 srll_pkg::ADDR_CAP : addsum[23:0];
                  end
                  if (!pos[0]) begin
                    pend_next = h;
                  end else if (pos == 10'd3) begin
                    if (v > 9'(srll_pkg::LINE_BYTES) && fault == srll_pkg::ST_OK) begin
                      fault_next = srll_pkg::ST_LENGTH;
                    end
                    bc_next   = v[7:0];
                    rsum_next = rsum + v[7:0];
                  end else if (fault == srll_pkg::ST_OK && pos < lim) begin
                    lb_we     = (idx < 10'(srll_pkg::LINE_BYTES));
                    rsum_next = rsum + v[7:0];
                  end
                end
                if (pos < srll_pkg::POS_CAP) begin
                  pos_next = pos + 10'd1;
                end
              end
            end
            srll_pkg::OP_EOL: begin
              if (latched) begin
                res_kind_next   = 1'b0;
                res_status_next = srll_pkg::ST_IGNORED;
                res_bad_next    = '0;
                pos_next        = '0;
                rkind_next      = '0;
                bc_next         = '0;
                pend_next       = '0;
                rsum_next       = '0;
                raddr_next      = '0;
                fault_next      = srll_pkg::ST_OK;
                state_next      = srll_pkg::BK_EMIT;
              end else begin
                state_next = srll_pkg::BK_CHECK;
              end
            end
            default: begin
              ra_r_next  = op.addr;
              state_next = srll_pkg::BK_READ;
            end
          endcase
        end
      end

      srll_pkg::BK_CLEAR: begin
        pm_we = 1'b1;
        pm_wd = (32'(clr_cnt) < srll_pkg::KERNEL_AREA &&
                 (clr_cnt % 18'(srll_pkg::ERASE_BLOCK)) == '0) ? 8'h00 : 8'hFF;
        clr_cnt_next = clr_cnt + 18'd1;
        if (clr_cnt == 18'(srll_pkg::MEM_BYTES - 1)) begin
          state_next = srll_pkg::BK_IDLE;
        end
      end

      srll_pkg::BK_CHECK: begin
        res_kind_next   = 1'b0;
        res_bad_next    = '0;
        res_status_next = srll_pkg::ST_OK;
        state_next      = srll_pkg::BK_EMIT;
        if (pos == 10'd0 || fault == srll_pkg::ST_NO_S) begin
          res_status_next = srll_pkg::ST_NO_S;
        end else if (fault == srll_pkg::ST_LENGTH || pos < lim) begin
          res_status_next = srll_pkg::ST_LENGTH;
        end else if (rsum != 8'hFF) begin
          res_status_next = srll_pkg::ST_CHECKSUM;
        end else if (rkind == srll_pkg::CHAR_0 || rkind == srll_pkg::CHAR_8 ||
                     rkind == srll_pkg::CHAR_9) begin
          res_status_next = srll_pkg::ST_OK;
        end else if (rkind != srll_pkg::CHAR_1 && rkind != srll_pkg::CHAR_2) begin
          res_status_next = srll_pkg::ST_TYPE;
        end else if (bc < {6'd0, srll_pkg::addr_len(rkind)} + 8'd1) begin
          res_status_next = srll_pkg::ST_LENGTH;
        end else if (bc != {6'd0, srll_pkg::addr_len(rkind)} + 8'd1) begin
          alen_next  = srll_pkg::addr_len(rkind);
          k_next     = '0;
          state_next = srll_pkg::BK_WR_RD;
        end
        if (state_next == srll_pkg::BK_EMIT) begin
          latched_next = (res_status_next != srll_pkg::ST_OK);
          pos_next     = '0;
          rkind_next   = '0;
          bc_next      = '0;
          pend_next    = '0;
          rsum_next    = '0;
          raddr_next   = '0;
          fault_next   = srll_pkg::ST_OK;
        end
      end

      srll_pkg::BK_WR_RD: begin
        if (wa_full >= 25'(srll_pkg::MEM_BYTES)) begin
          res_status_next = srll_pkg::ST_BAD_ADDR;
          res_bad_next    = wa_full[23:0];
          latched_next    = 1'b1;
          pos_next        = '0;
          rkind_next      = '0;
          bc_next         = '0;
          pend_next       = '0;
          rsum_next       = '0;
          raddr_next      = '0;
          fault_next      = srll_pkg::ST_OK;
          state_next      = srll_pkg::BK_EMIT;
        end else begin
          state_next = srll_pkg::BK_WR_WR;
        end
      end

      srll_pkg::BK_WR_WR: begin
        pm_we = 1'b1;
        pm_wa = wa_full[17:0];
        pm_wd = lb_q;
        if ({1'b0, wa_full[17:0]} + 19'd1 > hw) begin
          hw_next = {1'b0, wa_full[17:0]} + 19'd1;
        end
        k_next = k + 8'd1;
        if (k + 8'd1 == ndata) begin
          res_status_next = srll_pkg::ST_OK;
          res_bad_next    = '0;
          pos_next        = '0;
          rkind_next      = '0;
          bc_next         = '0;
          pend_next       = '0;
          rsum_next       = '0;
          raddr_next      = '0;
          fault_next      = srll_pkg::ST_OK;
          state_next      = srll_pkg::BK_EMIT;
        end else begin
          state_next = srll_pkg::BK_WR_RD;
        end
      end

      srll_pkg::BK_READ: begin
        res_kind_next   = 1'b1;
        res_status_next = srll_pkg::ST_OK;
        res_bad_next    = '0;
        state_next      = srll_pkg::BK_EMIT;
      end

      srll_pkg::BK_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit_load  = 1'b1;
          state_next = srll_pkg::BK_IDLE;
        end
      end

      default: state_next = srll_pkg::BK_IDLE;
    endcase
  end

endmodule

/* rtl/srecord_line_loader_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srecord_line_loader_top
// S-record text loader: decodes lines into a program memory.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   input    in_valid / in_stall   command, char_code, read_address
//   output   out_valid / out_stall kind, status, bad_address, max_address,
//                                  read_data
//
// A plain character is handled in the idle state; an LF passes a check state, then
// a read state and a write state per data byte written (the line buffer read feeds
// the memory write), then the result slot, and goes straight to the result slot when
// an error is latched; a read passes a fetch state, then the result slot. A clear walks
// the memory once, one byte per cycle. Reset clears control state only; memory is
// undefined until a clear. A stalled output holds the back end in its result slot;
// the front queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module srecord_line_loader_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [17:0] read_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [2:0]  status,
  output logic [23:0] bad_address,
  output logic [18:0] max_address,
  output logic [7:0]  read_data
);

  srll_pkg::op_t f_op;
  srll_pkg::op_t q_op;
  logic          f_valid;
  logic          q_stall;
  logic          q_valid;
  logic          q_pop;

  srll_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .char_code    (char_code),
    .read_address (read_address),
    .op_valid     (f_valid),
    .op_stall     (q_stall),
    .op           (f_op)
  );

  srll_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_stall (q_stall),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_op     (q_op)
  );

  srll_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (q_valid),
    .op_pop      (q_pop),
    .op          (q_op),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .status      (status),
    .bad_address (bad_address),
    .max_address (max_address),
    .read_data   (read_data)
  );

endmodule

/* tb/sv/srecord_line_loader_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srecord_line_loader_top_tb
// Self-checking bench for the S-record line loader. Feeds records, broken
// lines, noise and memory reads, predicts each line status and read result
// from its own model of the loader, and compares field by field.
// ----------------------------------------------------------------------------
module srecord_line_loader_top_tb;
  import srll_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        kind;
    status_t     st;
    logic [23:0] bad;
    logic [18:0] maxa;
    logic [7:0]  rd;
  } load_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = CMD_CHAR;
  logic [7:0]  char_code = 8'h00;
  logic [17:0] read_address = 18'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        kind;
  logic [2:0]  status;
  logic [23:0] bad_address;
  logic [18:0] max_address;
  logic [7:0]  read_data;

  srecord_line_loader_top dut (.*);

  always #5 clk = ~clk;

  // loader image kept by the bench
  logic [7:0]  mem_img [0:MEM_BYTES-1];
  logic [7:0]  line_buf [0:LINE_BYTES-1];
  int unsigned char_pos;
  logic [7:0]  rec_kind;
  logic [7:0]  rec_count;
  logic [4:0]  nibble;
  logic [7:0]  byte_sum;
  int unsigned rec_addr;
  int unsigned top_written;
  logic        err_latch;
  status_t     line_fault;

  load_result_t pending_results[$];
  logic [7:0]   line_q[$];

  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_ok_lines = 0;
  int n_err_lines = 0;
  int n_reads = 0;
  longint cycles = 0;
  logic idle_on = 1'b1;
  logic hold_trig = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int unsigned last_addr = 0;

  function automatic int unsigned addr_span(input logic [7:0] k);
    if (k == CHAR_2) return 3;
    if (k == CHAR_1) return 2;
    return 0;
  endfunction

  function automatic void reset_line();
    char_pos = 0;
    rec_kind = 8'h00;
    rec_count = 8'h00;
    nibble = 5'h0;
    byte_sum = 8'h00;
    rec_addr = 0;
    line_fault = ST_OK;
  endfunction

  function automatic void take_char(input logic [7:0] ch);
    int unsigned h, digits, d, s, v, idx, span;
    span = 4 + 2 * rec_count;
    if (char_pos == 0) begin
      if (ch != CHAR_S) line_fault = ST_NO_S;
    end else if (char_pos == 1) begin
      rec_kind = ch;
    end else begin
      h = (ch >= CHAR_0 && ch <= CHAR_9) ? ch[3:0] : ch[3:0] + 9;
      if (char_pos >= 4 && char_pos < span) begin
        digits = 2 * addr_span(rec_kind);
        d = char_pos - 4;
        if (d < digits) begin
          s = rec_addr + (h << (4 * (digits - 1 - d)));
          rec_addr = (s > 32'hFFFFFF) ? 32'hFFFFFF : s;
        end
      end
      if (char_pos % 2 == 0) begin
        nibble = h[4:0];
      end else begin
        v = (int'(nibble) << 4) + h;
        if (char_pos == 3) begin
          if ((v > 255 || v > LINE_BYTES) && line_fault == ST_OK) line_fault = ST_LENGTH;
          rec_count = v[7:0];
          byte_sum = byte_sum + v[7:0];
        end else if (line_fault == ST_OK && char_pos < span) begin
          idx = (char_pos - 5) / 2;
          if (idx < LINE_BYTES) line_buf[idx] = v[7:0];
          byte_sum = byte_sum + v[7:0];
        end
      end
    end
    if (char_pos < POS_CAP) char_pos++;
  endfunction

  function automatic status_t close_line(output logic [23:0] bad);
    int unsigned alen, ndata, a, idx;
    bad = '0;
    if (char_pos == 0 || line_fault == ST_NO_S) return ST_NO_S;
    if (line_fault == ST_LENGTH) return ST_LENGTH;
    if (char_pos < 4 + 2 * rec_count) return ST_LENGTH;
    if (byte_sum != 8'hFF) return ST_CHECKSUM;
    if (rec_kind == CHAR_0 || rec_kind == CHAR_8 || rec_kind == CHAR_9) return ST_OK;
    if (rec_kind != CHAR_1 && rec_kind != CHAR_2) return ST_TYPE;
    alen = addr_span(rec_kind);
    if (rec_count < alen + 1) return ST_LENGTH;
    ndata = rec_count - 1 - alen;
    for (int k = 0; k < ndata; k++) begin
      a = rec_addr + k;
      idx = alen + k;
      if (a >= MEM_BYTES) begin
        bad = a[23:0];
        return ST_BAD_ADDR;
      end
      mem_img[a] = (idx < LINE_BYTES) ? line_buf[idx] : 8'h00;
      if (a + 1 > top_written) top_written = a + 1;
      last_addr = a;
    end
    return ST_OK;
  endfunction

  function automatic void loader_predict(input logic [1:0] cmd, input logic [7:0] ch,
                                         input logic [17:0] ra);
    load_result_t r;
    logic [23:0] bad;
    r = '{1'b0, ST_OK, 24'h0, 19'h0, 8'h00};
    case (cmd)
      CMD_CLEAR: begin
        for (int a = 0; a < MEM_BYTES; a++) mem_img[a] = 8'hFF;
        for (int a = 0; a < KERNEL_AREA && a < MEM_BYTES; a += ERASE_BLOCK) mem_img[a] = 8'h00;
      end
      CMD_START: begin
        reset_line();
        top_written = 0;
        err_latch = 1'b0;
      end
      CMD_READ: begin
        r.kind = 1'b1;
        r.maxa = top_written[18:0];
        r.rd = mem_img[ra];
        pending_results.push_back(r);
        n_reads++;
      end
      default: begin
        if (ch != CHAR_LF) begin
          if (!err_latch) take_char(ch);
        end else begin
          bad = '0;
          if (err_latch) begin
            r.st = ST_IGNORED;
          end else begin
            r.st = close_line(bad);
            if (r.st != ST_OK) err_latch = 1'b1;
            if (r.st == ST_OK) n_ok_lines++; else n_err_lines++;
          end
          reset_line();
          r.bad = bad;
          r.maxa = top_written[18:0];
          pending_results.push_back(r);
        end
      end
    endcase
  endfunction

  // sender: entered and left just after a rising edge (or at the start)
  task automatic send_req(input logic [1:0] cmd, input logic [7:0] ch, input logic [17:0] ra);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    char_code <= ch;
    read_address <= ra;
    do @(posedge clk); while (in_stall);
    n_items++;
    loader_predict(cmd, ch, ra);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    go_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_req(CMD_CHAR, line_q[i], 18'($urandom));
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    string digits;
    logic [7:0] c;
    digits = "0123456789ABCDEF";
    c = digits[n];
    if (n > 9 && $urandom_range(0, 3) == 0) c = c + 8'h20;
    return c;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    line_q.push_back(hex_char(b[7:4]));
    line_q.push_back(hex_char(b[3:0]));
  endfunction

  // record with given type, address width and data length; sum_skew spoils the checksum
  function automatic void build_record(input logic [7:0] kc, input int alen,
                                       input int unsigned addr, input int ndata,
                                       input logic [7:0] sum_skew, input logic tail_cr);
    logic [7:0] cnt, s, b;
    line_q = {};
    line_q.push_back(CHAR_S);
    line_q.push_back(kc);
    cnt = 8'(alen + ndata + 1);
    s = cnt;
    push_byte(cnt);
    for (int i = alen - 1; i >= 0; i--) begin
      b = 8'(addr >> (8 * i));
      s = s + b;
      push_byte(b);
    end
    for (int i = 0; i < ndata; i++) begin
      b = 8'($urandom);
      s = s + b;
      push_byte(b);
    end
    push_byte(8'hFF - s + sum_skew);
    if (tail_cr) line_q.push_back(8'h0D);
    line_q.push_back(CHAR_LF);
  endfunction

  task automatic record(input logic [7:0] kc, input int alen, input int unsigned addr,
                        input int ndata);
    build_record(kc, alen, addr, ndata, 8'h00, 1'($urandom_range(0, 1)));
    send_line();
  endtask

  task automatic restart();
    send_req(CMD_START, 8'($urandom), 18'($urandom));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    load_result_t w;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", kind, 0);
      end else begin
        w = pending_results.pop_front();
        if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (bad_address !== w.bad) report_mismatch("bad_address", bad_address, w.bad);
        if (max_address !== w.maxa) report_mismatch("max_address", max_address, w.maxa);
        if (read_data !== w.rd) report_mismatch("read_data", read_data, w.rd);
      end
    end
  end

  // result side: random stalls plus a long hold on request
  always @(negedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 37);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("srecord_line_loader_top test failed");
      $finish;
    end
  end

  task automatic test_clear_and_start();
    send_req(CMD_CLEAR, 8'hFF, 18'h3FFFF);
    restart();
    send_req(CMD_READ, 8'h00, 18'h00000);
    send_req(CMD_READ, 8'h00, 18'h01000);
    send_req(CMD_READ, 8'h00, 18'h08000);
    send_req(CMD_READ, 8'h00, 18'h3FFFF);
    drain();
  endtask

  task automatic test_good_records();
    record(CHAR_0, 2, 0, 3);
    record(CHAR_1, 2, 16'h1234, 4);
    record(CHAR_2, 3, 24'h3FFFC, 4);
    record(CHAR_1, 2, 16'hFFFE, 125);
    record(CHAR_1, 2, 16'h0100, 0);
    record(CHAR_9, 2, 0, 0);
    record(CHAR_8, 3, 0, 0);
    send_req(CMD_READ, 8'h00, 18'h01234);
    send_req(CMD_READ, 8'h00, 18'h3FFFF);
    drain();
  endtask

  task automatic test_line_errors();
    line_q = {CHAR_LF};
    send_line();
    send_line();
    restart();
    line_q = {8'h73, CHAR_1, CHAR_LF};
    send_line();
    restart();
    build_record(CHAR_1, 2, 16'h2000, 2, 8'h01, 1'b0);
    send_line();
    restart();
    build_record(8'h35, 2, 0, 1, 8'h00, 1'b0);
    send_line();
    restart();
    build_record(CHAR_1, 2, 16'h3000, 4, 8'h00, 1'b0);
    line_q = line_q[0:line_q.size()-4];
    line_q.push_back(CHAR_LF);
    send_line();
    restart();
    line_q = {CHAR_S, CHAR_1, 8'h38, 8'h31, CHAR_LF};
    send_line();
    restart();
    line_q = {CHAR_S, CHAR_1, 8'h7A, 8'h7A, CHAR_LF};
    send_line();
    restart();
    build_record(CHAR_1, 0, 0, 1, 8'h00, 1'b0);
    send_line();
    restart();
    build_record(CHAR_2, 2, 16'h1111, 0, 8'h00, 1'b0);
    send_line();
    restart();
    drain();
  endtask

  task automatic test_bad_address();
    record(CHAR_2, 3, 24'h3FFFE, 4);
    send_req(CMD_READ, 8'h00, 18'h3FFFE);
    restart();
    record(CHAR_2, 3, 24'hFFFFFF, 1);
    restart();
    drain();
  endtask

  task automatic test_output_hold();
    go_idle();
    hold_trig = ~hold_trig;
    for (int i = 0; i < 30; i++) send_req(CMD_READ, 8'($urandom), 18'($urandom));
    record(CHAR_1, 2, 16'h4000, 6);
    drain();
  endtask

  task automatic random_line();
    int r, alen, nd;
    int unsigned addr;
    r = $urandom_range(0, 99);
    if (err_latch && $urandom_range(0, 1)) begin
      restart();
    end else if (r < 6) begin
      restart();
    end else if (r < 20) begin
      addr = $urandom_range(0, 1) ? last_addr : $urandom;
      send_req(CMD_READ, 8'($urandom), addr[17:0]);
    end else if (r < 28) begin
      line_q = {};
      if ($urandom_range(0, 1)) line_q.push_back(CHAR_S);
      repeat ($urandom_range(0, 12)) line_q.push_back(8'($urandom));
      line_q.push_back(CHAR_LF);
      send_line();
    end else if (r < 36) begin
      build_record($urandom_range(0, 1) ? CHAR_1 : CHAR_2, 2, $urandom, $urandom_range(0, 8),
                   8'($urandom_range(0, 2)), 1'b0);
      if ($urandom_range(0, 1)) begin
        line_q = line_q[0:$urandom_range(0, line_q.size() - 2)];
        line_q.push_back(CHAR_LF);
      end
      send_line();
    end else begin
      nd = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 12);
      if ($urandom_range(0, 1)) begin
        alen = 2;
        addr = $urandom_range(0, 16'hFFFF);
        record(CHAR_1, alen, addr, nd);
      end else begin
        alen = 3;
        addr = ($urandom_range(0, 9) == 0) ? $urandom_range(24'h3FF00, 24'hFFFFFF)
                                          : $urandom_range(0, 24'h3FFFF - nd);
        record(CHAR_2, alen, addr, nd);
      end
    end
  endtask

  task automatic test_random_load();
    int start_items;
    start_items = n_items;
    while (n_items - start_items < 500) begin
      idle_on = !((n_items - start_items) >= 150 && (n_items - start_items) < 300);
      random_line();
    end
    idle_on = 1'b1;
    drain();
  endtask

  task automatic test_clear_again();
    send_req(CMD_CLEAR, 8'($urandom), 18'($urandom));
    send_req(CMD_READ, 8'h00, 18'h02000);
    send_req(CMD_READ, 8'h00, last_addr[17:0]);
    drain();
  endtask

  initial begin
    reset_line();
    top_written = 0;
    err_latch = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_clear_and_start();
    test_good_records();
    test_line_errors();
    test_bad_address();
    test_output_hold();
    test_random_load();
    test_clear_again();
    repeat (100) @(posedge clk);
    $display("Covered %0d requests, %0d results: %0d lines loaded, %0d faulted, %0d reads.",
             n_items, n_results, n_ok_lines, n_err_lines, n_reads);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("srecord_line_loader_top test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("srecord_line_loader_top test failed");
    end
    $finish;
  end

endmodule
